// ===== src/tbbe_pkg.sv =====
package tbbe_pkg;

  localparam int ENTRY_W     = 17;
  localparam int HOP_W       = 24;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_LOOKUPS = 11;

  // lookup slots
  localparam int LK_X       = 0;
  localparam int LK_Y       = 1;
  localparam int LK_Z       = 2;
  localparam int LK_XPY     = 3;
  localparam int LK_XMY     = 4;
  localparam int LK_X2      = 5;
  localparam int LK_Y2      = 6;
  localparam int LK_XPZ     = 7;
  localparam int LK_XMZ     = 8;
  localparam int LK_YPZ     = 9;
  localparam int LK_YMZ     = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATTICE_MODE  = 4'd0,
    REG_HOP_NEAR      = 4'd1,
    REG_HOP_NEAR_BAR  = 4'd2,
    REG_HOP_DIAG      = 4'd3,
    REG_HOP_THIRD     = 4'd4,
    REG_HOP_VERT      = 4'd5,
    REG_HOP_VERT_BAR  = 4'd6,
    REG_HOP_VERT_DIAG = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] energy_one;
    logic signed [31:0] energy_two;
    logic signed [31:0] energy_three;
  } out_item_t;

  typedef struct packed {
    logic                    lattice_mode;
    logic signed [HOP_W-1:0] hop_near;
    logic signed [HOP_W-1:0] hop_near_bar;
    logic signed [HOP_W-1:0] hop_diag;
    logic signed [HOP_W-1:0] hop_third;
    logic signed [HOP_W-1:0] hop_vert;
    logic signed [HOP_W-1:0] hop_vert_bar;
    logic signed [HOP_W-1:0] hop_vert_diag;
  } hop_cfg_t;

endpackage

// ===== src/tight_binding_band_energy_core.sv =====
// Tight-binding band energies of one momentum point. A request carries three
// phase angles (a full circle is 2^ANGLE_BITS) and returns energy_one,
// energy_two and energy_three in signed Q16.16, rounded and saturated. One
// point is accepted per clock while the queue has room; a queued point passes
// through registered table read, cosine sums, hopping multiply, accumulate and
// round steps, all held while the output stalls. The rate is set by the eleven
// quarter-wave cosine tables, one read port each. A four-deep queue between
// front and back lets input flow on a stalled output. Configuration writes are
// always ready and should only be issued while no request is in flight.
module tight_binding_band_energy_core #(
  parameter int ANGLE_BITS      = 16,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbbe_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbbe_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbbe_pkg::HOP_W-1:0]          cfg_data
);
  import tbbe_pkg::*;

  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int LK_W  = NUM_LOOKUPS * (IDX_W + 1);

  hop_cfg_t         cfg_r;
  logic [LK_W-1:0]  lk_front, lk_head;
  logic             q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_LATTICE_MODE:  cfg_r.lattice_mode  <= cfg_data[0];
        REG_HOP_NEAR:      cfg_r.hop_near      <= cfg_data;
        REG_HOP_NEAR_BAR:  cfg_r.hop_near_bar  <= cfg_data;
        REG_HOP_DIAG:      cfg_r.hop_diag      <= cfg_data;
        REG_HOP_THIRD:     cfg_r.hop_third     <= cfg_data;
        REG_HOP_VERT:      cfg_r.hop_vert      <= cfg_data;
        REG_HOP_VERT_BAR:  cfg_r.hop_vert_bar  <= cfg_data;
        REG_HOP_VERT_DIAG: cfg_r.hop_vert_diag <= cfg_data;
        default: ;
      endcase
    end
  end

  tbbe_front #(
    .ANGLE_BITS      (ANGLE_BITS),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .IDX_W           (IDX_W)
  ) u_front (
    .item (in_data),
    .lk_o (lk_front)
  );

  assign in_ready = !q_full;

  tbbe_queue #(
    .WIDTH (LK_W),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (lk_front),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (lk_head)
  );

  tbbe_back #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .IDX_W           (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (lk_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/tbbe_front.sv =====
module tbbe_front #(
  parameter int ANGLE_BITS      = 16,
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int IDX_W           = 11
) (
  input  tbbe_pkg::in_item_t                             item,
  output logic [tbbe_pkg::NUM_LOOKUPS*(IDX_W+1)-1:0]     lk_o
);
  import tbbe_pkg::*;

  localparam int PW     = ANGLE_BITS + $clog2(COS_TABLE_DEPTH + 1);
  localparam int QSIZE  = 1 << (ANGLE_BITS - 2);
  localparam int HALF_Q = QSIZE / 2;

  logic [ANGLE_BITS-1:0] ax, ay, az;
  logic [ANGLE_BITS-1:0] ang [NUM_LOOKUPS];

  assign ax = ANGLE_BITS'(item.angle_x);
  assign ay = ANGLE_BITS'(item.angle_y);
  assign az = ANGLE_BITS'(item.angle_z);

  // sum, difference and doubled phases wrap naturally
  assign ang[LK_X]   = ax;
  assign ang[LK_Y]   = ay;
  assign ang[LK_Z]   = az;
  assign ang[LK_XPY] = ax + ay;
  assign ang[LK_XMY] = ax - ay;
  assign ang[LK_X2]  = ax << 1;
  assign ang[LK_Y2]  = ay << 1;
  assign ang[LK_XPZ] = ax + az;
  assign ang[LK_XMZ] = ax - az;
  assign ang[LK_YPZ] = ay + az;
  assign ang[LK_YMZ] = ay - az;

  always_comb begin
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] pos;
    logic [PW-1:0]         prod;
    logic [PW-1:0]         idxf;
    lk_o = '0;
    for (int i = 0; i < NUM_LOOKUPS; i++) begin
      quad = ang[i][ANGLE_BITS-1:ANGLE_BITS-2];
      pos  = {1'b0, ang[i][ANGLE_BITS-3:0]};
      if (quad[0]) begin
        pos = (ANGLE_BITS-1)'(QSIZE) - pos;
      end
      prod = PW'(pos) * PW'(COS_TABLE_DEPTH) + PW'(HALF_Q);
      idxf = prod >> (ANGLE_BITS - 2);
      if (idxf > PW'(COS_TABLE_DEPTH)) begin
        idxf = PW'(COS_TABLE_DEPTH);
      end
      lk_o[i*(IDX_W+1) +: (IDX_W+1)] = {quad[1] ^ quad[0], idxf[IDX_W-1:0]};
    end
  end

endmodule

// ===== src/tbbe_queue.sv =====
module tbbe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/tbbe_cos_rom.sv =====
module tbbe_cos_rom #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 11
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ADDR_W-1:0]            addr,
  output logic [tbbe_pkg::ENTRY_W-1:0] data_r
);
  import tbbe_pkg::*;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned HalfDepth = DEPTH / 2;

  typedef logic [ENTRY_W-1:0] tbl_t [DEPTH+1];

  // quarter-wave cosine, truncated taylor series in q2.30
  function automatic logic [ENTRY_W-1:0] cos_entry(input longint unsigned i);
    longint unsigned x, x2, term, k;
    longint          s;
    x    = (i * HalfPiQ30 + HalfDepth) / DEPTH;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    s    = longint'(term);
    for (k = 1; k <= 10; k++) begin
      term = (term * x2) >> 30;
      // divide by (2k-1)(2k)
      case (k)
        1:       term = term / 2;
        2:       term = term / 12;
        3:       term = term / 30;
        4:       term = term / 56;
        5:       term = term / 90;
        6:       term = term / 132;
        7:       term = term / 182;
        8:       term = term / 240;
        9:       term = term / 306;
        default: term = term / 380;
      endcase
      if (k[0]) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    return ENTRY_W'((s + 64'sd8192) >>> 14);
  endfunction

  function automatic tbl_t build_tbl();
    tbl_t t;
    for (int i = 0; i <= DEPTH; i++) begin
      t[i] = cos_entry(longint'(i));
    end
    return t;
  endfunction

  localparam tbl_t CosTbl = build_tbl();

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= CosTbl[addr];
    end
  end

endmodule

// ===== src/tbbe_back.sv =====
module tbbe_back #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int IDX_W           = 11
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  tbbe_pkg::hop_cfg_t                         cfg,
  input  logic                                       q_valid,
  input  logic [tbbe_pkg::NUM_LOOKUPS*(IDX_W+1)-1:0] q_data,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output tbbe_pkg::out_item_t                        out_data
);
  import tbbe_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [ENTRY_W-1:0]     rom_q   [NUM_LOOKUPS];
  logic [NUM_LOOKUPS-1:0] neg_r;
  logic signed [17:0]     c       [NUM_LOOKUPS];

  logic signed [18:0] sxy_r, sdiag_r, sthird_r;
  logic signed [17:0] cz_r;
  logic signed [19:0] zsum_r;
  logic signed [36:0] czs_r;

  logic signed [42:0] p1_r, p2_r, p3a_r, p3b_r, pvl_r, pvh_r;
  logic signed [41:0] p1z_r, p2z_r;
  logic signed [43:0] pvc_r;

  logic signed [45:0] a1_r, a2_r;
  logic signed [65:0] a3_r;
  logic signed [65:0] zpart;

  out_item_t res_r;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign en        = !v5_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = v5_r;
  assign out_data  = res_r;

  for (genvar g = 0; g < NUM_LOOKUPS; g++) begin : g_rom
    tbbe_cos_rom #(
      .DEPTH  (COS_TABLE_DEPTH),
      .ADDR_W (IDX_W)
    ) u_rom (
      .clk    (clk),
      .en     (en),
      .addr   (q_data[g*(IDX_W+1) +: IDX_W]),
      .data_r (rom_q[g])
    );
    assign c[g] = neg_r[g] ? -$signed({1'b0, rom_q[g]}) : $signed({1'b0, rom_q[g]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // sign flags ride along with the table reads
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LOOKUPS; i++) begin
        neg_r[i] <= q_data[i*(IDX_W+1) + IDX_W];
      end
    end
  end

  // cosine sums and the cos z times (cos x + cos y) product
  always_ff @(posedge clk) begin
    if (en) begin
      sxy_r    <= 19'(c[LK_X]) + 19'(c[LK_Y]);
      cz_r     <= c[LK_Z];
      sdiag_r  <= 19'(c[LK_XPY]) + 19'(c[LK_XMY]);
      sthird_r <= 19'(c[LK_X2]) + 19'(c[LK_Y2]);
      zsum_r   <= 20'(c[LK_XPZ]) + 20'(c[LK_XMZ]) + 20'(c[LK_YPZ]) + 20'(c[LK_YMZ]);
      czs_r    <= 37'(c[LK_Z]) * (37'(c[LK_X]) + 37'(c[LK_Y]));
    end
  end

  // hopping products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= 43'(cfg.hop_near) * 43'(sxy_r);
      p1z_r <= 42'(cfg.hop_vert) * 42'(cz_r);
      p2_r  <= 43'(cfg.hop_near_bar) * 43'(sxy_r);
      p2z_r <= 42'(cfg.hop_vert_bar) * 42'(cz_r);
      p3a_r <= 43'(cfg.hop_diag) * 43'(sdiag_r);
      p3b_r <= 43'(cfg.hop_third) * 43'(sthird_r);
      pvc_r <= 44'(cfg.hop_vert_diag) * 44'(zsum_r);
      pvl_r <= 43'(cfg.hop_vert_diag) * 43'($signed({1'b0, czs_r[17:0]}));
      pvh_r <= 43'(cfg.hop_vert_diag) * 43'($signed(czs_r[36:18]));
    end
  end

  assign zpart = cfg.lattice_mode
               ? (((66'(pvh_r) <<< 18) + 66'(pvl_r)) <<< 1)
               : (66'(pvc_r) <<< 17);

  // band accumulations
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= (46'(p1_r) <<< 1) + (cfg.lattice_mode ? 46'(p1z_r) : (46'(p1z_r) <<< 1));
      a2_r <= (46'(p2_r) <<< 1) + (cfg.lattice_mode ? 46'(p2z_r) : (46'(p2z_r) <<< 1));
      a3_r <= ((66'(p3a_r) + 66'(p3b_r)) <<< 17) + zpart;
    end
  end

  // negate, round half up, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.energy_one   <= sat32((67'sd32768 - 67'(a1_r)) >>> 16);
      res_r.energy_two   <= sat32((67'sd32768 - 67'(a2_r)) >>> 16);
      res_r.energy_three <= sat32((67'sd2147483648 - 67'(a3_r)) >>> 32);
    end
  end

endmodule
